FILE: src/pcxu_pkg.sv
package pcxu_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_DEPTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_ROW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam logic [1:0] DEPTH_1BIT = 2'd0;
    localparam logic [1:0] DEPTH_2BIT = 2'd1;
    localparam logic [1:0] DEPTH_4BIT = 2'd2;
    localparam logic [1:0] DEPTH_8BIT = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RUN_LONG = 2'd1;
    localparam logic [1:0] STATUS_TRUNC    = 2'd2;

    localparam logic [1:0] RUN_MARK_BITS  = 2'b11;
    localparam logic [5:0] RUN_COUNT_MASK = 6'h3F;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [63:0] group;
        logic [3:0]  keep;
        logic [15:0] column_next;
    } group_res_t;

endpackage

FILE: src/pcxu_byte_if.sv
interface pcxu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

FILE: src/pcxu_group_if.sv
interface pcxu_group_if;
    logic        valid;
    logic        ready;
    logic [63:0] pixel_group;
    logic [3:0]  pixel_count;
    logic [15:0] column;
    logic [15:0] row;
    logic        last_of_run;
    logic        row_end;
    logic        image_done;
    logic [1:0]  status;

    modport source (
        output valid, output pixel_group, output pixel_count, output column,
        output row, output last_of_run, output row_end, output image_done,
        output status, input ready
    );
    modport sink (
        input valid, input pixel_group, input pixel_count, input column,
        input row, input last_of_run, input row_end, input image_done,
        input status, output ready
    );
endinterface

FILE: src/pcx_rle_pixel_unpacker.sv
// Single-plane PCX run-length unpacker. Bytes arrive on stream, one item per
// byte; each decoded byte leaves on pixels as one group of up to eight pixel
// indices, clipped to image_width, tagged with its column and row. A literal
// byte is accepted in ST_IDLE and then gives its group from ST_EMIT; a run
// marker is taken with no group, and its value byte then holds stream off
// while ST_EMIT emits one group per repeat (up to 63), the shared group unit
// splitting the byte again for each column, and while pixels stalls.
// Runs longer than bytes_per_row end decoding with status 1, end_of_data
// before the last row gives one empty group with status 2; after that every
// item is swallowed until reset. Configuration must be written through cfg_we,
// cfg_index and cfg_data only while no group is pending; the block does not enforce it.
module pcx_rle_pixel_unpacker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pcxu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pcxu_pkg::CFG_DATA_W-1:0]   cfg_data,
    pcxu_byte_if.sink                         stream,
    pcxu_group_if.source                      pixels
);
    import pcxu_pkg::*;

    // configuration
    logic [1:0]  depth_reg;
    logic [15:0] bpr_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;

    // decoder state
    state_t      state_reg, state_next;
    logic        await_reg;
    logic [5:0]  pending_reg;
    logic        err_pend_reg;
    logic [15:0] rbl_reg;
    logic [15:0] column_reg;
    logic [15:0] row_reg;
    logic        finished_reg;

    // run being emitted
    logic [7:0]  value_reg;
    logic [5:0]  reps_left_reg;
    logic        empty_reg;
    logic        rend_reg;
    logic        done_reg;
    logic [1:0]  status_reg;

    // output register
    logic        out_valid_reg;
    logic [63:0] out_group_reg;
    logic [3:0]  out_count_reg;
    logic [15:0] out_column_reg;
    logic [15:0] out_row_reg;
    logic        out_last_reg;
    logic        out_rend_reg;
    logic        out_done_reg;
    logic [1:0]  out_status_reg;

    logic        accept;
    logic        slot_free;
    logic        emit_fire;
    logic        emit_last;
    logic [15:0] eff_bpr;
    logic [15:0] eff_height;
    logic [15:0] rbl_eff;
    logic        is_marker;
    logic [5:0]  reps;
    logic        err;
    logic [15:0] rbl_new;
    logic        rend;
    logic        done;
    logic        take_byte;
    logic        take_marker;
    logic        start_run;
    logic        start_trunc;
    group_res_t  unit_res;

    pcxu_group_unit u_group (
        .value  (value_reg),
        .depth  (depth_reg),
        .column (column_reg),
        .width  (width_reg),
        .res    (unit_res)
    );

    // accept side decode
    always_comb
    begin
        eff_bpr     = (bpr_reg == 16'd0) ? 16'd1 : bpr_reg;
        eff_height  = (height_reg == 16'd0) ? 16'd1 : height_reg;
        rbl_eff     = (rbl_reg == 16'd0) ? eff_bpr : rbl_reg;
        is_marker   = (stream.data_byte[7:6] == RUN_MARK_BITS);
        reps        = await_reg ? pending_reg : 6'd1;
        err         = await_reg ? err_pend_reg : 1'b0;
        rbl_new     = ({10'b0, reps} >= rbl_eff) ? 16'd0 : rbl_eff - {10'b0, reps};
        rend        = (rbl_new == 16'd0);
        done        = err || (rend && (({1'b0, row_reg} + 17'd1) >= {1'b0, eff_height}));
        take_byte   = accept && !finished_reg && !stream.end_of_data;
        take_marker = take_byte && !await_reg && is_marker;
        start_run   = take_byte && !take_marker && ((reps != 6'd0) || err);
        start_trunc = accept && !finished_reg && stream.end_of_data;
    end

    always_comb
    begin
        slot_free = !out_valid_reg || pixels.ready;
        emit_last = empty_reg || (reps_left_reg == 6'd1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_run || start_trunc)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        stream.ready = 1'b0;
        emit_fire    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                stream.ready = 1'b1;
            end
            ST_EMIT:
            begin
                emit_fire = slot_free;
            end
            default:
            begin
                stream.ready = 1'b0;
            end
        endcase
        accept = stream.valid && stream.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= DEPTH_8BIT;
            bpr_reg    <= 16'd1;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_DEPTH:   depth_reg  <= cfg_data[1:0];
                CFG_BYTES_PER_ROW: bpr_reg    <= cfg_data;
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                default:           depth_reg  <= depth_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            await_reg     <= 1'b0;
            pending_reg   <= 6'd0;
            err_pend_reg  <= 1'b0;
            rbl_reg       <= 16'd0;
            column_reg    <= 16'd0;
            row_reg       <= 16'd0;
            finished_reg  <= 1'b0;
            value_reg     <= 8'd0;
            reps_left_reg <= 6'd0;
            empty_reg     <= 1'b0;
            rend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (take_marker)
            begin
                pending_reg  <= stream.data_byte[5:0] & RUN_COUNT_MASK;
                err_pend_reg <= ({10'b0, stream.data_byte[5:0]} > eff_bpr);
                await_reg    <= 1'b1;
                rbl_reg      <= rbl_eff;
            end
            else if (take_byte)
            begin
                await_reg    <= 1'b0;
                err_pend_reg <= 1'b0;
            end
            else if (start_trunc)
            begin
                await_reg <= 1'b0;
            end

            if (start_run)
            begin
                rbl_reg       <= rbl_new;
                value_reg     <= stream.data_byte;
                reps_left_reg <= reps;
                empty_reg     <= (reps == 6'd0);
                rend_reg      <= rend;
                done_reg      <= done;
                status_reg    <= err ? STATUS_RUN_LONG : STATUS_OK;
            end
            else if (start_trunc)
            begin
                empty_reg  <= 1'b1;
                rend_reg   <= 1'b0;
                done_reg   <= 1'b1;
                status_reg <= STATUS_TRUNC;
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
                if (!empty_reg)
                begin
                    reps_left_reg <= reps_left_reg - 6'd1;
                end
                if (emit_last && rend_reg)
                begin
                    // row moves on only once the whole run is out
                    column_reg <= 16'd0;
                    if (row_reg != 16'hFFFF)
                    begin
                        row_reg <= row_reg + 16'd1;
                    end
                end
                else if (!empty_reg)
                begin
                    column_reg <= unit_res.column_next;
                end
                if (emit_last && done_reg)
                begin
                    finished_reg <= 1'b1;
                end
            end
            else if (pixels.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_group_reg  <= empty_reg ? 64'd0 : unit_res.group;
            out_count_reg  <= empty_reg ? 4'd0 : unit_res.keep;
            out_column_reg <= column_reg;
            out_row_reg    <= row_reg;
            out_last_reg   <= emit_last;
            out_rend_reg   <= emit_last && rend_reg;
            out_done_reg   <= emit_last && done_reg;
            out_status_reg <= emit_last ? status_reg : STATUS_OK;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_group = out_group_reg;
    assign pixels.pixel_count = out_count_reg;
    assign pixels.column      = out_column_reg;
    assign pixels.row         = out_row_reg;
    assign pixels.last_of_run = out_last_reg;
    assign pixels.row_end     = out_rend_reg;
    assign pixels.image_done  = out_done_reg;
    assign pixels.status      = out_status_reg;

    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && (pixels.status != STATUS_OK))
            |-> (pixels.last_of_run && pixels.image_done))
        else $error("error status on a group that does not end the image");

    a_row_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.row_end) |-> pixels.last_of_run)
        else $error("row end flagged before the end of a run");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid |-> (pixels.pixel_count <= 4'd8))
        else $error("pixel count above eight");

    a_quiet_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && finished_reg) |=> (state_reg == ST_IDLE))
        else $error("decoder restarted after finishing");

endmodule

FILE: src/pcxu_group_unit.sv
module pcxu_group_unit (
    input  logic [7:0]               value,
    input  logic [1:0]               depth,
    input  logic [15:0]              column,
    input  logic [15:0]              width,
    output pcxu_pkg::group_res_t     res
);
    import pcxu_pkg::*;

    logic [7:0]  pix [8];
    logic [3:0]  n;
    logic [15:0] room;
    logic [16:0] sum;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            pix[i] = 8'h00;
        end
        unique case (depth)
            DEPTH_1BIT:
            begin
                // single bit pixels come out inverted
                for (int i = 0; i < 8; i++)
                begin
                    pix[i] = {7'b0, ~value[7-i]};
                end
                n = 4'd8;
            end
            DEPTH_2BIT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    pix[i] = {6'b0, value[7-2*i -: 2]};
                end
                n = 4'd4;
            end
            DEPTH_4BIT:
            begin
                pix[0] = {4'b0, value[7:4]};
                pix[1] = {4'b0, value[3:0]};
                n = 4'd2;
            end
            default:
            begin
                pix[0] = value;
                n = 4'd1;
            end
        endcase
    end

    always_comb
    begin
        room = width - column;
        if (column >= width)
        begin
            res.keep = 4'd0;
        end
        else if (room < {12'b0, n})
        begin
            res.keep = room[3:0];
        end
        else
        begin
            res.keep = n;
        end
        for (int i = 0; i < 8; i++)
        begin
            res.group[8*i +: 8] = (4'(i) < res.keep) ? pix[i] : 8'h00;
        end
        sum = {1'b0, column} + {13'b0, n};
        res.column_next = sum[16] ? 16'hFFFF : sum[15:0];
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pcxu_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 120;

    typedef struct packed {
        logic [63:0] pix;
        logic [3:0]  count;
        logic [15:0] col;
        logic [15:0] row;
        logic        last;
        logic        rend;
        logic        done;
        logic [1:0]  status;
    } pixel_group_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pcxu_byte_if  stream_if ();
    pcxu_group_if pixel_if ();

    pcx_rle_pixel_unpacker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream_if),
        .pixels    (pixel_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // decoder settings as last written
    logic [1:0]  depth_sel;
    logic [15:0] row_budget_cfg;
    logic [15:0] width_cfg;
    logic [15:0] height_cfg;

    // decoder state mirrored per accepted byte
    logic        want_run_byte;
    logic [5:0]  run_len;
    logic [16:0] budget_left;
    logic [15:0] next_col;
    logic [15:0] cur_row;
    logic        run_too_long;
    logic        stopped;

    pixel_group_t expected_groups[$];
    pixel_group_t head_group;
    int           mismatch_count = 0;

    int tx_calm_left   = 0;
    int rx_hold_req    = 0;
    int rx_stall_left  = 0;
    int rx_steady_left = 0;
    int rx_roll;
    int cycle_count;

    function automatic int row_budget();
        return (row_budget_cfg == 16'd0) ? 1 : int'(row_budget_cfg);
    endfunction

    // split one byte into pixels at the current column, clip to width, advance column
    function automatic pixel_group_t place_group(input logic [7:0] b);
        pixel_group_t g;
        logic [7:0]   pix [8];
        int           n;
        int           keep;
        int           nxt;
        g = '0;
        for (int i = 0; i < 8; i++)
            pix[i] = 8'd0;
        case (depth_sel)
            DEPTH_1BIT:
            begin
                for (int i = 0; i < 8; i++)
                    pix[i] = {7'd0, ~b[7-i]};
                n = 8;
            end
            DEPTH_2BIT:
            begin
                for (int i = 0; i < 4; i++)
                    pix[i] = {6'd0, b[7-2*i -: 2]};
                n = 4;
            end
            DEPTH_4BIT:
            begin
                pix[0] = {4'd0, b[7:4]};
                pix[1] = {4'd0, b[3:0]};
                n = 2;
            end
            default:
            begin
                pix[0] = b;
                n = 1;
            end
        endcase
        if (next_col >= width_cfg)
            keep = 0;
        else if (int'(width_cfg) - int'(next_col) < n)
            keep = int'(width_cfg) - int'(next_col);
        else
            keep = n;
        for (int i = 0; i < keep; i++)
            g.pix[8*i +: 8] = pix[i];
        g.count = keep[3:0];
        g.col   = next_col;
        g.row   = cur_row;
        nxt = int'(next_col) + n;
        next_col = (nxt > 65535) ? 16'hFFFF : nxt[15:0];
        return g;
    endfunction

    task automatic unpack_expected(input logic [7:0] b, input logic eod);
        int           reps;
        logic         err;
        logic         rend;
        logic         done;
        pixel_group_t g;
        if (stopped)
            return;
        if (eod)
        begin
            g = '0;
            g.col    = next_col;
            g.row    = cur_row;
            g.last   = 1'b1;
            g.done   = 1'b1;
            g.status = STATUS_TRUNC;
            expected_groups.push_back(g);
            stopped = 1'b1;
            want_run_byte = 1'b0;
            return;
        end
        if (!want_run_byte)
        begin
            if (budget_left == 17'd0)
                budget_left = 17'(row_budget());
            if (b[7:6] == RUN_MARK_BITS)
            begin
                run_len = b[5:0] & RUN_COUNT_MASK;
                run_too_long = (int'(run_len) > row_budget());
                want_run_byte = 1'b1;
                return;
            end
            reps = 1;
            err = 1'b0;
        end
        else
        begin
            reps = int'(run_len);
            err = run_too_long;
            want_run_byte = 1'b0;
            run_too_long = 1'b0;
        end
        if (reps == 0 && !err)
            return;
        budget_left = (reps >= int'(budget_left)) ? 17'd0 : budget_left - 17'(reps);
        rend = (budget_left == 17'd0);
        done = err || (rend && (int'(cur_row) + 1 >= ((height_cfg == 16'd0) ? 1 :
                                                      int'(height_cfg))));
        for (int r = 0; r < reps; r++)
        begin
            g = place_group(b);
            if (r < reps - 1)
                expected_groups.push_back(g);
        end
        // a too-long run with no groups still reports once
        if (reps == 0)
        begin
            g = '0;
            g.col = next_col;
            g.row = cur_row;
        end
        g.last   = 1'b1;
        g.rend   = rend;
        g.done   = done;
        g.status = err ? STATUS_RUN_LONG : STATUS_OK;
        expected_groups.push_back(g);
        if (rend)
        begin
            if (cur_row < 16'hFFFF)
                cur_row = cur_row + 16'd1;
            next_col = 16'd0;
        end
        if (done)
            stopped = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            if (expected_groups.size() == 0)
                report_mismatch("pixel group with nothing outstanding");
            else
            begin
                head_group = expected_groups.pop_front();
                if (pixel_if.pixel_group !== head_group.pix)
                    report_mismatch($sformatf("pixel_group %h, want %h (row %0d col %0d)",
                        pixel_if.pixel_group, head_group.pix, head_group.row, head_group.col));
                if (pixel_if.pixel_count !== head_group.count)
                    report_mismatch($sformatf("pixel_count %0d, want %0d",
                        pixel_if.pixel_count, head_group.count));
                if (pixel_if.column !== head_group.col)
                    report_mismatch($sformatf("column %0d, want %0d",
                        pixel_if.column, head_group.col));
                if (pixel_if.row !== head_group.row)
                    report_mismatch($sformatf("row %0d, want %0d",
                        pixel_if.row, head_group.row));
                if (pixel_if.last_of_run !== head_group.last)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                        pixel_if.last_of_run, head_group.last));
                if (pixel_if.row_end !== head_group.rend)
                    report_mismatch($sformatf("row_end %b, want %b",
                        pixel_if.row_end, head_group.rend));
                if (pixel_if.image_done !== head_group.done)
                    report_mismatch($sformatf("image_done %b, want %b",
                        pixel_if.image_done, head_group.done));
                if (pixel_if.status !== head_group.status)
                    report_mismatch($sformatf("status code %0d, want %0d",
                        pixel_if.status, head_group.status));
            end
        end
    end

    // output side: random stalls, calm stretches and the long hold on request
    always @(posedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_stall_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_stall_left > 0)
        begin
            pixel_if.ready <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_steady_left > 0)
        begin
            pixel_if.ready <= 1'b1;
            rx_steady_left--;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 3)
            begin
                rx_steady_left = $urandom_range(30, 120);
                pixel_if.ready <= 1'b1;
            end
            else if (rx_roll < 70)
                pixel_if.ready <= 1'b1;
            else
            begin
                pixel_if.ready <= 1'b0;
                rx_stall_left = (rx_roll < 97) ? $urandom_range(0, 3) : $urandom_range(15, 60);
            end
        end
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (tx_calm_left > 0)
        begin
            tx_calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            tx_calm_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eod, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.data_byte   <= b;
        stream_if.end_of_data <= eod;
        do
            @(posedge clk);
        while (!stream_if.ready);
        unpack_expected(b, eod);
    endtask

    task automatic send_run(input logic [5:0] len, input logic [7:0] b, input bit no_gap = 1'b0);
        send_byte({RUN_MARK_BITS, len}, 1'b0, no_gap);
        send_byte(b, 1'b0, no_gap);
    endtask

    task automatic drain_results();
        stream_if.valid <= 1'b0;
        while (expected_groups.size() != 0)
            @(posedge clk);
        // a run marker gives no group, let it settle too
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] depth, input logic [15:0] bpr,
                             input logic [15:0] width, input logic [15:0] height);
        drain_results();
        cfg_write(CFG_PIXEL_DEPTH, {14'd0, depth});
        cfg_write(CFG_BYTES_PER_ROW, bpr);
        cfg_write(CFG_IMAGE_WIDTH, width);
        cfg_write(CFG_IMAGE_HEIGHT, height);
        cfg_we <= 1'b0;
        depth_sel      = depth;
        row_budget_cfg = bpr;
        width_cfg      = width;
        height_cfg     = height;
    endtask

    // runs never exceed the row budget here, so decoding keeps going
    task automatic send_random_items(input int n, input bit no_gap = 1'b0);
        int         items_left;
        int         maxc;
        int         roll;
        logic [5:0] len;
        items_left = n;
        while (items_left > 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40 || items_left == 1)
            begin
                send_byte(8'($urandom_range(0, 8'hBF)), 1'b0, no_gap);
                items_left--;
            end
            else
            begin
                maxc = (row_budget() > 63) ? 63 : row_budget();
                if (roll < 55)
                    len = 6'(maxc);
                else if (roll < 63)
                    len = 6'd0;
                else
                    len = 6'($urandom_range(1, maxc));
                send_run(len, 8'($urandom_range(0, 255)), no_gap);
                items_left -= 2;
            end
        end
    endtask

    task automatic test_literal_and_run();
        configure(DEPTH_1BIT, 16'd4, 16'hFFFF, 16'hFFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_run(6'd0, 8'hFF);
        send_run(6'd2, 8'hA5);
    endtask

    task automatic test_pixel_depths();
        for (int d = DEPTH_2BIT; d <= DEPTH_8BIT; d++)
        begin
            configure(d[1:0], 16'd3, 16'd5, 16'hFFFF);
            send_byte(8'h9C, 1'b0);
            // overshoots the two bytes left in the row
            send_run(6'd3, 8'hE7);
        end
    endtask

    task automatic test_degenerate_sizes();
        configure(DEPTH_1BIT, 16'd0, 16'd0, 16'hFFFF);
        send_byte(8'h3C, 1'b0);
        send_run(6'd1, 8'h81);
    endtask

    task automatic test_long_runs();
        configure(DEPTH_4BIT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_run(6'd63, 8'hFF);
        send_run(6'd63, 8'h00);
    endtask

    task automatic test_output_stall();
        configure(2'($urandom_range(0, 3)), 16'hFFFF, 16'($urandom_range(1, 600)), 16'hFFFF);
        rx_hold_req = 300;
        for (int k = 0; k < 8; k++)
            send_run(6'($urandom_range(20, 63)), 8'($urandom_range(0, 255)), 1'b1);
        drain_results();
    endtask

    task automatic test_random_phases();
        logic [15:0] bpr;
        logic [15:0] width;
        for (int p = 0; p < 5; p++)
        begin
            case ($urandom_range(0, 4))
                0: bpr = 16'd0;
                1: bpr = 16'd1;
                2: bpr = 16'($urandom_range(2, 12));
                3: bpr = 16'($urandom_range(13, 200));
                default: bpr = 16'hFFFF;
            endcase
            // keep the leftover row budget small for the ending
            if (p == 4)
                bpr = 16'($urandom_range(0, 12));
            case ($urandom_range(0, 3))
                0: width = 16'd0;
                1: width = 16'($urandom_range(1, 16));
                2: width = 16'($urandom_range(17, 300));
                default: width = 16'hFFFF;
            endcase
            configure(2'($urandom_range(0, 3)), bpr, width,
                      16'($urandom_range(30000, 65535)));
            send_random_items(19);
            if ($urandom_range(0, 1))
                drain_results();
            send_random_items(19);
        end
    endtask

    task automatic test_stream_end();
        int         budget;
        logic [15:0] height;
        case ($urandom_range(0, 2))
            0:
            begin
                configure(2'($urandom_range(0, 3)), 16'($urandom_range(2, 20)),
                          16'($urandom_range(1, 64)), 16'hFFFF);
                send_random_items(4);
                // sometimes cut the stream between a marker and its value
                if ($urandom_range(0, 1))
                    send_byte({RUN_MARK_BITS, 6'($urandom_range(0, row_budget()))}, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            1:
            begin
                configure(2'($urandom_range(0, 3)), 16'($urandom_range(0, 20)),
                          16'($urandom_range(1, 64)), 16'hFFFF);
                budget = row_budget();
                send_run(6'($urandom_range(budget + 1, 63)), 8'($urandom_range(0, 255)));
            end
            default:
            begin
                height = $urandom_range(0, 1) ? 16'd0 : cur_row + 16'd1;
                configure(2'($urandom_range(0, 3)), 16'd8, 16'($urandom_range(1, 64)), height);
                for (int k = 0; k < 40 && !stopped; k++)
                    send_byte(8'($urandom_range(0, 8'hBF)), 1'b0);
            end
        endcase
        // stopped now: nothing that follows gives a group
        for (int k = 0; k < 4; k++)
            send_byte(8'($urandom_range(0, 255)),
                      (k == 3) ? 1'b1 : 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        stream_if.valid       = 1'b0;
        stream_if.data_byte   = 8'd0;
        stream_if.end_of_data = 1'b0;
        pixel_if.ready        = 1'b0;
        depth_sel      = DEPTH_8BIT;
        row_budget_cfg = 16'd1;
        width_cfg      = 16'd1;
        height_cfg     = 16'd1;
        want_run_byte  = 1'b0;
        run_len        = 6'd0;
        budget_left    = 17'd0;
        next_col       = 16'd0;
        cur_row        = 16'd0;
        run_too_long   = 1'b0;
        stopped        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literal_and_run();
        test_pixel_depths();
        test_degenerate_sizes();
        test_long_runs();
        test_output_stall();
        test_random_phases();
        test_stream_end();

        stream_if.valid <= 1'b0;
        for (int w = 0; w < 200000 && expected_groups.size() != 0; w++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_groups.size() != 0)
            report_mismatch($sformatf("%0d pixel groups never arrived", expected_groups.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
src/pcxu_pkg.sv
src/pcxu_byte_if.sv
src/pcxu_group_if.sv
src/pcxu_group_unit.sv
src/pcx_rle_pixel_unpacker.sv
sim/testbench.sv
